/* hdl/assert_macros.svh */
// assertion macros for the rtl files of the union-find engine
// no dependencies; included by the top level, the only file that carries concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);

`endif

/* hdl/ufsq_pkg.sv */
// types, codes and microcode program of the union-find size query engine
// no dependencies; imported by the sequencer, the datapath and the top level
`timescale 1ns / 1ps

package ufsq_pkg;

   localparam int NODE_W = 10;
   localparam int THR_W  = 11;
   localparam int SIZE_W = 11;
   localparam int OP_W   = 2;
   // wide enough for any node count of the parameter range
   localparam int EXT_W  = 17;

   localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
   localparam logic [OP_W-1:0] OP_UNION = 2'd1;
   localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

   localparam logic [SIZE_W-1:0] SIZE_MAX = '1;

   typedef logic [4:0] upc_type;
   typedef logic [3:0] cond_type;
   typedef logic [3:0] act_type;

   // jump conditions
   localparam cond_type C_NONE      = 4'd0;
   localparam cond_type C_ALWAYS    = 4'd1;
   localparam cond_type C_REQ       = 4'd2;
   localparam cond_type C_IS_CLEAR  = 4'd3;
   localparam cond_type C_SKIP_OP   = 4'd4;
   localparam cond_type C_FOUND     = 4'd5;
   localparam cond_type C_X_ROOT    = 4'd6;
   localparam cond_type C_CHAIN_END = 4'd7;
   localparam cond_type C_LAST      = 4'd8;
   localparam cond_type C_IS_QUERY  = 4'd9;
   localparam cond_type C_RSP_FREE  = 4'd10;

   // datapath actions
   localparam act_type A_NOP      = 4'd0;
   localparam act_type A_LOAD     = 4'd1;
   localparam act_type A_SEL_A    = 4'd2;
   localparam act_type A_RD_CUR   = 4'd3;
   localparam act_type A_FIND     = 4'd4;
   localparam act_type A_RD_X     = 4'd5;
   localparam act_type A_COMPRESS = 4'd6;
   localparam act_type A_SEL_B    = 4'd7;
   localparam act_type A_END_B    = 4'd8;
   localparam act_type A_RD_SIZE  = 4'd9;
   localparam act_type A_UNION    = 4'd10;
   localparam act_type A_QUERY    = 4'd11;
   localparam act_type A_RESP     = 4'd12;
   localparam act_type A_SWEEP    = 4'd13;

   typedef struct packed {
      cond_type cond;
      logic     hold;
      upc_type  target;
      act_type  act;
   } ucode_type;

   typedef struct packed {
      logic req_fire;
      logic is_clear;
      logic skip_op;
      logic found;
      logic x_root;
      logic chain_end;
      logic last;
      logic is_query;
      logic rsp_free;
   } status_type;

   // program addresses
   localparam upc_type P_RST   = 5'd0;
   localparam upc_type P_IDLE  = 5'd1;
   localparam upc_type P_DISP  = 5'd2;
   localparam upc_type P_CHECK = 5'd3;
   localparam upc_type P_FA0   = 5'd4;
   localparam upc_type P_FA1   = 5'd5;
   localparam upc_type P_FA2   = 5'd6;
   localparam upc_type P_FA3   = 5'd7;
   localparam upc_type P_SELB  = 5'd8;
   localparam upc_type P_FB0   = 5'd9;
   localparam upc_type P_FB1   = 5'd10;
   localparam upc_type P_FB2   = 5'd11;
   localparam upc_type P_FB3   = 5'd12;
   localparam upc_type P_ENDB  = 5'd13;
   localparam upc_type P_SIZE  = 5'd14;
   localparam upc_type P_UNION = 5'd15;
   localparam upc_type P_QUERY = 5'd16;
   localparam upc_type P_RESP  = 5'd17;
   localparam upc_type P_CLR   = 5'd18;

   function automatic ucode_type uw(input cond_type c, input logic h, input upc_type t,
                                    input act_type a);
      ucode_type w;
      w.cond   = c;
      w.hold   = h;
      w.target = t;
      w.act    = a;
      return w;
   endfunction

   // next address: target when the condition holds, else stay on hold, else step
   function automatic ucode_type ucode_rom(input upc_type addr);
      ucode_type w;
      unique case (addr)
         P_RST:   w = uw(C_LAST,      1'b1, P_IDLE,  A_SWEEP);
         P_IDLE:  w = uw(C_REQ,       1'b1, P_DISP,  A_LOAD);
         P_DISP:  w = uw(C_IS_CLEAR,  1'b0, P_CLR,   A_SEL_A);
         P_CHECK: w = uw(C_SKIP_OP,   1'b0, P_RESP,  A_NOP);
         P_FA0:   w = uw(C_NONE,      1'b0, P_FA0,   A_RD_CUR);
         P_FA1:   w = uw(C_FOUND,     1'b1, P_FA2,   A_FIND);
         P_FA2:   w = uw(C_X_ROOT,    1'b0, P_SELB,  A_RD_X);
         P_FA3:   w = uw(C_CHAIN_END, 1'b1, P_SELB,  A_COMPRESS);
         P_SELB:  w = uw(C_NONE,      1'b0, P_SELB,  A_SEL_B);
         P_FB0:   w = uw(C_NONE,      1'b0, P_FB0,   A_RD_CUR);
         P_FB1:   w = uw(C_FOUND,     1'b1, P_FB2,   A_FIND);
         P_FB2:   w = uw(C_X_ROOT,    1'b0, P_ENDB,  A_RD_X);
         P_FB3:   w = uw(C_CHAIN_END, 1'b1, P_ENDB,  A_COMPRESS);
         P_ENDB:  w = uw(C_NONE,      1'b0, P_ENDB,  A_END_B);
         P_SIZE:  w = uw(C_IS_QUERY,  1'b0, P_QUERY, A_RD_SIZE);
         P_UNION: w = uw(C_ALWAYS,    1'b0, P_RESP,  A_UNION);
         P_QUERY: w = uw(C_NONE,      1'b0, P_QUERY, A_QUERY);
         P_RESP:  w = uw(C_RSP_FREE,  1'b1, P_IDLE,  A_RESP);
         P_CLR:   w = uw(C_LAST,      1'b1, P_RESP,  A_SWEEP);
         default: w = uw(C_ALWAYS,    1'b0, P_IDLE,  A_NOP);
      endcase
      return w;
   endfunction

endpackage

/* hdl/union_find_size_query_engine.sv */
// Disjoint-set engine over NODES nodes, union by size with path compression.
// Requests arrive on the req_ stream: req_tuser carries the operation (clear, union,
// query), req_tdata the two node indices and the query threshold. Every request
// gives exactly one response on the rsp_ stream: merged flag, combined size and
// threshold flag.
// A microcoded sequencer runs one request at a time, and the parent memory port sets
// the pace. Each root search walks the parent links up to the root, then walks the
// path again and relinks every node on it to the root. req_tready rises in the same
// cycle as rsp_tvalid.
// Clear rewrites both memories one entry a cycle and then gives its response.
// After reset the same pass runs before req_tready first rises.
// The response sits in an output register; a new request is taken while it waits
// for rsp_tready, and the engine stalls only when it has a second response ready.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module union_find_size_query_engine #(
   parameter int NODES = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // node_a[9:0], node_b[19:10], threshold[30:20], zero
   input  logic [1:0]  req_tuser,   // operation[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata    // merged[0], combined_size[11:1], reached[12], zero
);
   import ufsq_pkg::*;

   ucode_type  ctrl;
   status_type status;
   upc_type    upc;

   logic       req_fire;
   logic       in_sweep;
   logic       resp_step;
   logic       rsp_stall;

   ufsq_sequencer u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctrl   (ctrl),
      .upc    (upc)
   );

   ufsq_datapath #(
      .NODES (NODES)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .act        (ctrl.act),
      .status     (status),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   assign req_fire  = req_tvalid && req_tready;
   assign in_sweep  = (upc == P_RST) || (upc == P_CLR);
   assign resp_step = (upc == P_RESP);
   assign rsp_stall = resp_step && rsp_tvalid && !rsp_tready;

   `ASSERT_NEXT(a_accept_dispatch, clock, reset, req_fire, upc == P_DISP, "no dispatch")
   `ASSERT_IMPLIES(a_sweep_blocks, clock, reset, in_sweep, !req_tready, "request during sweep")
   `ASSERT_IMPLIES(a_rsp_source, clock, reset, $rose(rsp_tvalid), $past(resp_step), "stray rsp")
   `ASSERT_NEXT(a_rsp_wait, clock, reset, rsp_stall, resp_step && rsp_tvalid, "response lost")

endmodule

/* hdl/ufsq_sequencer.sv */
// microcode sequencer: step counter, program table and conditional jumps
// depends on ufsq_pkg
`timescale 1ns / 1ps

module ufsq_sequencer (
   input  logic                  clock,
   input  logic                  reset,
   input  ufsq_pkg::status_type  status,
   output ufsq_pkg::ucode_type   ctrl,
   output ufsq_pkg::upc_type     upc
);
   import ufsq_pkg::*;

   upc_type upc_ff;
   upc_type upc_in;
   logic    cond_true;

   assign ctrl = ucode_rom(upc_ff);
   assign upc  = upc_ff;

   always_comb begin
      unique case (ctrl.cond)
         C_NONE:      cond_true = 1'b0;
         C_ALWAYS:    cond_true = 1'b1;
         C_REQ:       cond_true = status.req_fire;
         C_IS_CLEAR:  cond_true = status.is_clear;
         C_SKIP_OP:   cond_true = status.skip_op;
         C_FOUND:     cond_true = status.found;
         C_X_ROOT:    cond_true = status.x_root;
         C_CHAIN_END: cond_true = status.chain_end;
         C_LAST:      cond_true = status.last;
         C_IS_QUERY:  cond_true = status.is_query;
         C_RSP_FREE:  cond_true = status.rsp_free;
         default:     cond_true = 1'b0;
      endcase
   end

   always_comb begin
      if (cond_true) begin
         upc_in = ctrl.target;
      end else if (ctrl.hold) begin
         upc_in = upc_ff;
      end else begin
         upc_in = upc_ff + upc_type'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff <= P_RST;
      end else begin
         upc_ff <= upc_in;
      end
   end

endmodule

/* hdl/ufsq_datapath.sv */
// datapath: parent and size memories, walk registers, result register
// depends on ufsq_pkg; driven by the action field of ufsq_sequencer
`timescale 1ns / 1ps

module ufsq_datapath #(
   parameter int NODES = 1024
) (
   input  logic                  clock,
   input  logic                  reset,
   input  ufsq_pkg::act_type     act,
   output ufsq_pkg::status_type  status,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [31:0]           req_tdata,
   input  logic [1:0]            req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [15:0]           rsp_tdata
);
   import ufsq_pkg::*;

   localparam int NW = $clog2(NODES);

   logic [NW-1:0]     parent_mem [NODES];
   logic [SIZE_W-1:0] size_mem [NODES];

   logic [OP_W-1:0]   op_ff;
   logic [NODE_W-1:0] a_ff;
   logic [NODE_W-1:0] b_ff;
   logic [THR_W-1:0]  thr_ff;

   logic [NW-1:0]     x_ff;
   logic [NW-1:0]     cur_ff;
   logic [NW-1:0]     root_ff;
   logic [NW-1:0]     ra_ff;
   logic [NW-1:0]     rb_ff;
   logic [NW-1:0]     cnt_ff;
   logic [NW-1:0]     pdata_ff;
   logic [SIZE_W-1:0] sa_ff;
   logic [SIZE_W-1:0] sb_ff;

   logic              merged_ff;
   logic [SIZE_W-1:0] comb_ff;
   logic              reached_ff;
   logic              rsp_valid_ff;
   logic [15:0]       rsp_data_ff;

   logic [EXT_W-1:0]  a_ext;
   logic [EXT_W-1:0]  b_ext;
   logic [NW-1:0]     a_idx;
   logic [NW-1:0]     b_idx;
   logic              in_range;
   logic              req_fire;
   logic              rsp_free;
   logic              found;
   logic              last;
   logic              diff_root;
   logic [SIZE_W:0]   size_sum;
   logic [SIZE_W:0]   q_total;
   logic [SIZE_W-1:0] q_sat;
   logic [NW-1:0]     big;
   logic [NW-1:0]     small_root;

   logic              p_rd_en;
   logic [NW-1:0]     p_rd_addr;
   logic              p_wr_en;
   logic [NW-1:0]     p_wr_addr;
   logic [NW-1:0]     p_wr_data;
   logic              s_rd_en;
   logic              s_wr_en;
   logic [NW-1:0]     s_wr_addr;
   logic [SIZE_W-1:0] s_wr_data;

   assign a_ext    = EXT_W'(a_ff);
   assign b_ext    = EXT_W'(b_ff);
   assign a_idx    = a_ext[NW-1:0];
   assign b_idx    = b_ext[NW-1:0];
   assign in_range = (a_ext < EXT_W'(NODES)) && (b_ext < EXT_W'(NODES));

   assign req_tready = (act == A_LOAD);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign found      = (pdata_ff == cur_ff);
   assign last       = (cnt_ff == NW'(NODES - 1));
   assign diff_root  = (ra_ff != rb_ff);

   assign size_sum   = {1'b0, sa_ff} + {1'b0, sb_ff};
   assign q_total    = diff_root ? size_sum : {1'b0, sa_ff};
   assign q_sat      = q_total[SIZE_W] ? SIZE_MAX : q_total[SIZE_W-1:0];
   // on equal sizes the root of node_a stays root
   assign big        = (sb_ff > sa_ff) ? rb_ff : ra_ff;
   assign small_root = (sb_ff > sa_ff) ? ra_ff : rb_ff;

   assign status.req_fire  = req_fire;
   assign status.is_clear  = (op_ff == OP_CLEAR);
   assign status.skip_op   = !(((op_ff == OP_UNION) || (op_ff == OP_QUERY)) && in_range);
   assign status.found     = found;
   assign status.x_root    = (x_ff == root_ff);
   assign status.chain_end = (pdata_ff == root_ff);
   assign status.last      = last;
   assign status.is_query  = (op_ff == OP_QUERY);
   assign status.rsp_free  = rsp_free;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // memory port control
   always_comb begin
      p_rd_en   = 1'b0;
      p_rd_addr = cur_ff;
      p_wr_en   = 1'b0;
      p_wr_addr = cur_ff;
      p_wr_data = root_ff;
      s_rd_en   = 1'b0;
      s_wr_en   = 1'b0;
      s_wr_addr = big;
      s_wr_data = size_sum[SIZE_W-1:0];
      unique case (act)
         A_SWEEP: begin
            p_wr_en   = 1'b1;
            p_wr_addr = cnt_ff;
            p_wr_data = cnt_ff;
            s_wr_en   = 1'b1;
            s_wr_addr = cnt_ff;
            s_wr_data = SIZE_W'(1);
         end
         A_RD_CUR: begin
            p_rd_en = 1'b1;
         end
         A_FIND: begin
            p_rd_en   = !found;
            p_rd_addr = pdata_ff;
         end
         A_RD_X: begin
            p_rd_en   = 1'b1;
            p_rd_addr = x_ff;
         end
         A_COMPRESS: begin
            // relink the current node to the root and fetch the parent of its old parent
            p_wr_en   = 1'b1;
            p_rd_en   = 1'b1;
            p_rd_addr = pdata_ff;
         end
         A_RD_SIZE: begin
            s_rd_en = 1'b1;
         end
         A_UNION: begin
            p_wr_en   = diff_root;
            p_wr_addr = small_root;
            p_wr_data = big;
            s_wr_en   = diff_root;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (p_wr_en) begin
         parent_mem[p_wr_addr] <= p_wr_data;
      end
      if (p_rd_en) begin
         pdata_ff <= parent_mem[p_rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (s_wr_en) begin
         size_mem[s_wr_addr] <= s_wr_data;
      end
      if (s_rd_en) begin
         sa_ff <= size_mem[ra_ff];
         sb_ff <= size_mem[rb_ff];
      end
   end

   // walk and result registers
   always_ff @(posedge clock) begin
      case (act)
         A_LOAD: begin
            if (req_fire) begin
               op_ff  <= req_tuser;
               a_ff   <= req_tdata[9:0];
               b_ff   <= req_tdata[19:10];
               thr_ff <= req_tdata[30:20];
            end
         end
         A_SEL_A: begin
            x_ff       <= a_idx;
            cur_ff     <= a_idx;
            merged_ff  <= 1'b0;
            comb_ff    <= '0;
            reached_ff <= 1'b0;
         end
         A_FIND: begin
            if (found) begin
               root_ff <= cur_ff;
            end else begin
               cur_ff <= pdata_ff;
            end
         end
         A_RD_X: begin
            cur_ff <= x_ff;
         end
         A_COMPRESS: begin
            cur_ff <= pdata_ff;
         end
         A_SEL_B: begin
            ra_ff  <= root_ff;
            x_ff   <= b_idx;
            cur_ff <= b_idx;
         end
         A_END_B: begin
            rb_ff <= root_ff;
         end
         A_UNION: begin
            merged_ff <= diff_root;
         end
         A_QUERY: begin
            comb_ff    <= q_sat;
            reached_ff <= (q_total >= {1'b0, thr_ff});
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (act == A_SWEEP) begin
            cnt_ff <= last ? '0 : cnt_ff + NW'(1);
         end
         if ((act == A_RESP) && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if ((act == A_RESP) && rsp_free) begin
         rsp_data_ff <= {3'b000, reached_ff, comb_ff, merged_ff};
      end
   end

endmodule
